// File: rtl/radix2_dit_fft_inplace_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef RADIX2_DIT_FFT_INPLACE_UNIT_DEFINES_SVH
`define RADIX2_DIT_FFT_INPLACE_UNIT_DEFINES_SVH

// Clocked property that is ignored while reset is high.
`define R2FFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define R2FFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/r2fft_pkg.sv
package r2fft_pkg;

  // Configuration register indexes.
  localparam logic CFG_POINTS_LOG2 = 1'b0;
  localparam logic CFG_INVERSE     = 1'b1;

  localparam logic [3:0] POINTS_LOG2_RESET = 4'd10;

  // Pi in Q62.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  typedef enum logic [1:0] {
    WR_SAMPLE,
    WR_TOP,
    WR_BOT
  } wr_src_t;

  typedef struct packed {
    logic    wr_en;
    wr_src_t wr_src;
    logic    rd_en;
    logic    tw_load;
    logic    mul_load;
    logic    sum_load;
    logic    out_load;
    logic    inverse;
  } cmd_t;

  // Quarter-wave cosine entry k of a table with 2^lmax steps per quarter,
  // Taylor series in Q30, rounded half up to twf fraction bits, saturated.
  function automatic longint cos_q(input int k, input int lmax, input int twf);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  u;
    logic [127:0] prod;
    longint       c;
    longint       r;
    longint       maxv;
    int           n;
    prod = 128'(PI_Q62 >> (lmax + 1)) * 128'(k);
    x    = prod[63:0] >> 32;
    prod = 128'(x) * 128'(x);
    x2   = prod[63:0] >> 30;
    u    = 64'd1 << 30;
    c    = longint'(1) << 30;
    n    = 0;
    maxv = (longint'(1) << twf) - 1;
    for (int i = 0; i < 24; i++) begin
      if (u != 64'd0) begin
        prod = 128'(u) * 128'(x2);
        u = (prod[63:0] >> 30) / 64'((2 * n + 1) * (2 * n + 2));
        n++;
        if ((n % 2) == 1) c = c - longint'(u);
        else c = c + longint'(u);
      end
    end
    if (c < 0) c = 0;
    if (twf < 30) r = (c + (longint'(1) << (29 - twf))) >>> (30 - twf);
    else if (twf == 30) r = c;
    else r = c * 2;
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

// File: rtl/r2fft_if.sv
interface r2fft_in_if #(
  parameter int IDX_W    = 10,
  parameter int SAMPLE_W = 16
);
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [IDX_W-1:0]           index;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;
  logic                       last;

  modport source (output valid, cmd, index, sample_re, sample_im, last, input ready);
  modport sink (input valid, cmd, index, sample_re, sample_im, last, output ready);
endinterface

interface r2fft_out_if #(
  parameter int IDX_W  = 10,
  parameter int DATA_W = 26
);
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_re;
  logic signed [DATA_W-1:0] out_im;
  logic [IDX_W-1:0]         out_index;

  modport source (output valid, out_re, out_im, out_index, input ready);
  modport sink (input valid, out_re, out_im, out_index, output ready);
endinterface

// File: rtl/r2fft_ctrl.sv
module r2fft_ctrl #(
  parameter int LOG2_MAX_POINTS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [3:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [LOG2_MAX_POINTS-1:0] in_index,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output r2fft_pkg::cmd_t            cmd,
  output logic [LOG2_MAX_POINTS-1:0] rd_addr_a,
  output logic [LOG2_MAX_POINTS-1:0] rd_addr_b,
  output logic [LOG2_MAX_POINTS-1:0] wr_addr,
  output logic [LOG2_MAX_POINTS:0]   tw_ix
);

  localparam int L  = LOG2_MAX_POINTS;
  localparam int SW = $clog2(L + 1);

  typedef enum logic [2:0] {
    IDLE, RD_WAIT, BF_TW, BF_RD, BF_MUL, BF_SUM, BF_WTOP, BF_WBOT
  } state_t;

  state_t        state;
  logic [3:0]    points_log2;
  logic          inverse;
  logic [SW-1:0] n_lim;
  logic [SW-1:0] stage;
  logic [L-1:0]  bfly;
  logic [L:0]    top;
  logic [L:0]    half;
  logic [L:0]    size;
  logic [L:0]    bot;
  logic [L+1:0]  top_next;
  logic [L:0]    bfly_next;
  logic [SW-1:0] n_eff;
  logic          accept;

  assign half      = (L + 1)'(1) << (stage - SW'(1));
  assign size      = (L + 1)'(1) << n_lim;
  assign bot       = top + half;
  assign top_next  = (L + 2)'(top) + ((L + 2)'(half) << 1);
  assign bfly_next = (L + 1)'(bfly) + (L + 1)'(1);
  assign in_ready  = !rst && (state == IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  // Clamp the configured size into the supported range.
  always_comb begin
    if (points_log2 == 4'd0) n_eff = SW'(1);
    else if (int'(points_log2) > L) n_eff = SW'(L);
    else n_eff = SW'(points_log2);
  end

  always_comb begin
    cmd         = '0;
    cmd.inverse = inverse;
    cmd.wr_src  = r2fft_pkg::WR_SAMPLE;
    rd_addr_a   = top[L-1:0];
    rd_addr_b   = bot[L-1:0];
    wr_addr     = top[L-1:0];
    tw_ix       = (L + 1)'(bfly) << (L + 2 - int'(stage));
    case (state)
      IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            cmd.rd_en = 1'b1;
            rd_addr_a = in_index;
          end else begin
            cmd.wr_en = 1'b1;
            wr_addr   = in_index;
          end
        end
      end
      RD_WAIT: cmd.out_load = 1'b1;
      BF_TW:   cmd.tw_load = 1'b1;
      BF_RD:   cmd.rd_en = 1'b1;
      BF_MUL:  cmd.mul_load = 1'b1;
      BF_SUM:  cmd.sum_load = 1'b1;
      BF_WTOP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = r2fft_pkg::WR_TOP;
      end
      BF_WBOT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = r2fft_pkg::WR_BOT;
        wr_addr    = bot[L-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      points_log2 <= r2fft_pkg::POINTS_LOG2_RESET;
      inverse     <= 1'b0;
      n_lim       <= '0;
      stage       <= '0;
      bfly        <= '0;
      top         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          r2fft_pkg::CFG_POINTS_LOG2: points_log2 <= cfg_data;
          r2fft_pkg::CFG_INVERSE:     inverse <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            if (in_cmd) begin
              state <= RD_WAIT;
            end else if (in_last) begin
              n_lim <= n_eff;
              stage <= SW'(1);
              bfly  <= '0;
              top   <= '0;
              state <= BF_TW;
            end
          end
        end
        RD_WAIT: begin
          out_valid <= 1'b1;
          state     <= IDLE;
        end
        BF_TW:   state <= BF_RD;
        BF_RD:   state <= BF_MUL;
        BF_MUL:  state <= BF_SUM;
        BF_SUM:  state <= BF_WTOP;
        BF_WTOP: state <= BF_WBOT;
        BF_WBOT: begin
          if (top_next < (L + 2)'(size)) begin
            top   <= top_next[L:0];
            state <= BF_RD;
          end else if (bfly_next < half) begin
            bfly  <= bfly_next[L-1:0];
            top   <= bfly_next;
            state <= BF_TW;
          end else if (stage < n_lim) begin
            stage <= stage + SW'(1);
            bfly  <= '0;
            top   <= '0;
            state <= BF_TW;
          end else begin
            stage <= '0;
            bfly  <= '0;
            top   <= '0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/r2fft_dp.sv
module r2fft_dp #(
  parameter int LOG2_MAX_POINTS = 10,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int TWIDDLE_WIDTH   = 18
) (
  input  logic                                             clk,
  input  r2fft_pkg::cmd_t                                  cmd,
  input  logic [LOG2_MAX_POINTS-1:0]                       rd_addr_a,
  input  logic [LOG2_MAX_POINTS-1:0]                       rd_addr_b,
  input  logic [LOG2_MAX_POINTS-1:0]                       wr_addr,
  input  logic [LOG2_MAX_POINTS:0]                         tw_ix,
  input  logic signed [SAMPLE_WIDTH-1:0]                   sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]                   sample_im,
  output logic signed [SAMPLE_WIDTH+LOG2_MAX_POINTS-1:0]   out_re,
  output logic signed [SAMPLE_WIDTH+LOG2_MAX_POINTS-1:0]   out_im,
  output logic [LOG2_MAX_POINTS-1:0]                       out_index
);

  localparam int L    = LOG2_MAX_POINTS;
  localparam int MAXP = 1 << L;
  localparam int DW   = SAMPLE_WIDTH + L;
  localparam int TW   = TWIDDLE_WIDTH;
  localparam int TWF  = TW - 1;
  localparam int PW   = DW + TW;
  localparam logic signed [PW+1:0] SAT_HI = (PW + 2)'((longint'(1) << (DW - 1)) - 1);
  localparam logic signed [PW+1:0] SAT_LO = -SAT_HI - (PW + 2)'(1);
  localparam logic signed [PW:0]   RND    = (PW + 1)'(longint'(1) << (TWF - 1));

  logic [2*DW-1:0]       mem [0:MAXP-1];
  logic [2*DW-1:0]       dout_a;
  logic [2*DW-1:0]       dout_b;
  logic [2*DW-1:0]       wr_data;
  logic [L-1:0]          idx_q;
  logic signed [TW-1:0]  cos_rom [0:MAXP];
  logic [L+1:0]          ix_w;
  logic [L:0]            rom_a;
  logic [L:0]            rom_b;
  logic                  neg;
  logic signed [TW-1:0]  wr;
  logic signed [TW-1:0]  wi;
  logic signed [PW-1:0]  p_rr;
  logic signed [PW-1:0]  p_ii;
  logic signed [PW-1:0]  p_ri;
  logic signed [PW-1:0]  p_ir;
  logic signed [PW:0]    tr_w;
  logic signed [PW:0]    ti_w;
  logic signed [PW:0]    tr;
  logic signed [PW:0]    ti;
  logic signed [DW-1:0]  top_re;
  logic signed [DW-1:0]  top_im;
  logic signed [DW-1:0]  bot_re;
  logic signed [DW-1:0]  bot_im;
  logic signed [DW-1:0]  new_top_re;
  logic signed [DW-1:0]  new_top_im;
  logic signed [DW-1:0]  new_bot_re;
  logic signed [DW-1:0]  new_bot_im;

  function automatic logic signed [DW-1:0] sat(input logic signed [PW+1:0] v);
    if (v > SAT_HI) return DW'(SAT_HI);
    if (v < SAT_LO) return DW'(SAT_LO);
    return DW'(v);
  endfunction

  for (genvar k = 0; k <= MAXP; k++) begin : g_rom
    localparam logic signed [TW-1:0] ENTRY = TW'(r2fft_pkg::cos_q(k, L, TWF));
    assign cos_rom[k] = ENTRY;
  end

  // Fold the twiddle angle into the first quadrant of the cosine table.
  always_comb begin
    ix_w = (L + 2)'(tw_ix);
    if (ix_w <= (L + 2)'(MAXP)) begin
      rom_a = tw_ix;
      rom_b = (L + 1)'((L + 2)'(MAXP) - ix_w);
      neg   = 1'b0;
    end else begin
      rom_a = (L + 1)'((L + 2)'(2 * MAXP) - ix_w);
      rom_b = (L + 1)'(ix_w - (L + 2)'(MAXP));
      neg   = 1'b1;
    end
  end

  assign top_re = dout_a[2*DW-1:DW];
  assign top_im = dout_a[DW-1:0];
  assign bot_re = dout_b[2*DW-1:DW];
  assign bot_im = dout_b[DW-1:0];

  assign tr_w = (PW + 1)'(p_rr) - (PW + 1)'(p_ii) + RND;
  assign ti_w = (PW + 1)'(p_ri) + (PW + 1)'(p_ir) + RND;
  assign tr   = tr_w >>> TWF;
  assign ti   = ti_w >>> TWF;

  always_comb begin
    case (cmd.wr_src)
      r2fft_pkg::WR_TOP: wr_data = {new_top_re, new_top_im};
      r2fft_pkg::WR_BOT: wr_data = {new_bot_re, new_bot_im};
      default:           wr_data = {DW'(sample_re), DW'(sample_im)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      dout_a <= mem[rd_addr_a];
      dout_b <= mem[rd_addr_b];
      idx_q  <= rd_addr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tw_load) begin
      wr <= neg ? -cos_rom[rom_a] : cos_rom[rom_a];
      wi <= cmd.inverse ? cos_rom[rom_b] : -cos_rom[rom_b];
    end
    if (cmd.mul_load) begin
      p_rr <= bot_re * wr;
      p_ii <= bot_im * wi;
      p_ri <= bot_re * wi;
      p_ir <= bot_im * wr;
    end
    if (cmd.sum_load) begin
      new_top_re <= sat((PW + 2)'(top_re) + (PW + 2)'(tr));
      new_top_im <= sat((PW + 2)'(top_im) + (PW + 2)'(ti));
      new_bot_re <= sat((PW + 2)'(top_re) - (PW + 2)'(tr));
      new_bot_im <= sat((PW + 2)'(top_im) - (PW + 2)'(ti));
    end
    if (cmd.out_load) begin
      out_re    <= top_re;
      out_im    <= top_im;
      out_index <= idx_q;
    end
  end

endmodule

// File: rtl/radix2_dit_fft_inplace_unit.sv
// In-place radix-2 decimation-in-time FFT over an on-chip sample memory.
// The input channel carries write and read items. A write (cmd 0) stores one
// complex Q1.15 sample at index; samples must arrive in bit-reversed order.
// A write with last set starts the transform over the first 2^points_log2
// entries (points_log2 clamped to 1..LOG2_MAX_POINTS) once the sample is
// stored. A read (cmd 1) returns one bin in natural order on the output
// channel, together with its index. Writes transfer one per cycle while idle
// with no result stalled; a read's result passes the memory read and output
// registers, and no item is taken before it is presented. A sequencer runs the
// transform around one butterfly unit: each butterfly does a memory read,
// multiply, add and two writes on the single write port, each new twiddle adds
// a table load, and no item is taken while the transform runs.
// Configuration writes (points_log2, inverse) are taken at any time but are
// meant only while the unit is idle. Reset returns to idle with size 1024 and
// the forward transform; the sample memory is not cleared. A stalled output
// holds its result and the unit takes no further item until it transfers.
module radix2_dit_fft_inplace_unit #(
  parameter int LOG2_MAX_POINTS = 10,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int TWIDDLE_WIDTH   = 18
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  r2fft_in_if.sink   in_ch,
  r2fft_out_if.source out_ch
);

  r2fft_pkg::cmd_t             cmd;
  logic [LOG2_MAX_POINTS-1:0]  rd_addr_a;
  logic [LOG2_MAX_POINTS-1:0]  rd_addr_b;
  logic [LOG2_MAX_POINTS-1:0]  wr_addr;
  logic [LOG2_MAX_POINTS:0]    tw_ix;

  // The sequencer owns the handshakes, the configuration and the loop counters.
  r2fft_ctrl #(
    .LOG2_MAX_POINTS(LOG2_MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_index  (in_ch.index),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .tw_ix     (tw_ix)
  );

  // The datapath holds the sample memory, the twiddle table and the butterfly.
  r2fft_dp #(
    .LOG2_MAX_POINTS(LOG2_MAX_POINTS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .TWIDDLE_WIDTH  (TWIDDLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .tw_ix     (tw_ix),
    .sample_re (in_ch.sample_re),
    .sample_im (in_ch.sample_im),
    .out_re    (out_ch.out_re),
    .out_im    (out_ch.out_im),
    .out_index (out_ch.out_index)
  );

endmodule

// File: rtl/r2fft_checker.sv
`include "radix2_dit_fft_inplace_unit_defines.svh"

module r2fft_checker #(
  parameter int DATA_W = 26
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_re
);

  logic rd_xfer;
  logic go_xfer;

  assign rd_xfer = in_valid && in_ready && in_cmd;
  assign go_xfer = in_valid && in_ready && !in_cmd && in_last;

  `R2FFT_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid, "output valid after reset")
  `R2FFT_ASSERT(a_result_src, $rose(out_valid) |-> $past(rd_xfer, 2), "result without read")
  `R2FFT_ASSERT(a_read_gap, rd_xfer |=> !in_ready, "item taken right after a read")
  `R2FFT_ASSERT(a_run_busy, go_xfer |=> !in_ready, "item taken as transform starts")
  `R2FFT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_re)),
    "stalled result changed")

endmodule

bind radix2_dit_fft_inplace_unit r2fft_checker #(
  .DATA_W(SAMPLE_WIDTH + LOG2_MAX_POINTS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_re    (out_ch.out_re)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_HALF   = 4;
  localparam int RST_CYCLES = 5;
  localparam int DEPTH      = 1024;
  localparam int TW_MAX     = 131071;
  // The limit allows several times the largest transform, during which nothing
  // is transferred.
  localparam int IDLE_LIMIT = 150000;
  localparam int RAND_ITEMS = 80;

  typedef struct {
    logic signed [25:0] re;
    logic signed [25:0] im;
    logic [9:0]         idx;
  } bin_t;

  // One row of the directed part. When has_exp is set, the bin that the
  // read returns is typed in; otherwise it comes from the predictor.
  typedef struct {
    bit                 cmd;
    int                 idx;
    int                 re;
    int                 im;
    bit                 last;
    bit                 has_exp;
    int                 exp_re;
    int                 exp_im;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_data;

  r2fft_in_if  #(.IDX_W(10), .SAMPLE_W(16)) in_ch ();
  r2fft_out_if #(.IDX_W(10), .DATA_W(26))   out_ch ();

  radix2_dit_fft_inplace_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow copy of the sample memory, the twiddle table and the settings.
  longint   shadow_re [DEPTH];
  longint   shadow_im [DEPTH];
  bit       stored [DEPTH];
  longint   cos_rom [DEPTH + 1];
  int       size_code;
  bit       inv_mode;

  bin_t     pending_bins[$];
  int       errors;
  int       items;
  int       settle_cycles;
  bit       calm;
  bit       stim_done;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Quarter-wave cosine in Q30 by Taylor series, rounded to 17 fraction bits.
  function automatic longint quarter_cos(int k);
    logic [127:0] p;
    logic [63:0]  ang;
    logic [63:0]  ang_sq;
    logic [63:0]  term;
    longint       acc;
    longint       q;
    int           j;
    p      = 128'(r2fft_pkg::PI_Q62 >> 11) * 128'(k);
    ang    = p[63:0] >> 32;
    p      = 128'(ang) * 128'(ang);
    ang_sq = p[63:0] >> 30;
    term   = 64'd1 << 30;
    acc    = longint'(1) << 30;
    j      = 0;
    while (term != 64'd0 && j < 24) begin
      p    = 128'(term) * 128'(ang_sq);
      term = (p[63:0] >> 30) / 64'((2 * j + 1) * (2 * j + 2));
      j++;
      if (j % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    q = (acc + (longint'(1) << 12)) >>> 13;
    return (q > TW_MAX) ? TW_MAX : q;
  endfunction

  function automatic longint clip26(longint v);
    longint hi;
    hi = (longint'(1) << 25) - 1;
    return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
  endfunction

  // Product sum at twiddle scale, rounded half up back to data scale.
  function automatic longint round_tw(longint s);
    return (s + (longint'(1) << 16)) >>> 17;
  endfunction

  function automatic int eff_log2(int code);
    return (code < 1) ? 1 : ((code > 10) ? 10 : code);
  endfunction

  // Cycles the block needs for a transform of the given size, with margin.
  function automatic int fft_cycles(int code);
    int n;
    n = eff_log2(code);
    return 5 * (1 << (n - 1)) * n + (1 << n) + 40;
  endfunction

  function automatic bit span_stored(int code);
    for (int i = 0; i < (1 << eff_log2(code)); i++) if (!stored[i]) return 1'b0;
    return 1'b1;
  endfunction

  // In-place transform of the shadow memory over the first N entries.
  task automatic transform_shadow();
    int     n;
    int     span;
    int     half;
    int     tix;
    longint wr;
    longint ws;
    longint wi;
    longint tr;
    longint ti;
    longint pr;
    longint pi;
    n    = eff_log2(size_code);
    span = 1 << n;
    for (int s = 1; s <= n; s++) begin
      half = 1 << (s - 1);
      for (int b = 0; b < half; b++) begin
        tix = b << (12 - s);
        if (tix <= DEPTH) begin
          wr = cos_rom[tix];
          ws = cos_rom[DEPTH - tix];
        end else begin
          wr = -cos_rom[2 * DEPTH - tix];
          ws = cos_rom[tix - DEPTH];
        end
        wi = inv_mode ? ws : -ws;
        for (int t = b; t < span; t += 2 * half) begin
          tr = round_tw(shadow_re[t + half] * wr - shadow_im[t + half] * wi);
          ti = round_tw(shadow_re[t + half] * wi + shadow_im[t + half] * wr);
          pr = shadow_re[t];
          pi = shadow_im[t];
          shadow_re[t + half] = clip26(pr - tr);
          shadow_im[t + half] = clip26(pi - ti);
          shadow_re[t]        = clip26(pr + tr);
          shadow_im[t]        = clip26(pi + ti);
        end
      end
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Drops the input request, then waits until every expected bin has arrived
  // and a running transform is done.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
    settle_cycles = 0;
  endtask

  task automatic cfg_write(logic idx, logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(int code, bit inv);
    wait_idle();
    cfg_write(r2fft_pkg::CFG_POINTS_LOG2, 4'(code));
    cfg_write(r2fft_pkg::CFG_INVERSE, 4'(inv));
    size_code = code;
    inv_mode  = inv;
  endtask

  // Drives one item, waits for its transfer, then updates the shadow state.
  task automatic send(bit cmd, int idx, int re, int im, bit last, bit has_exp = 0,
                      int exp_re = 0, int exp_im = 0);
    int   gap;
    bin_t b;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.index     <= 10'(idx);
    in_ch.sample_re <= 16'(re);
    in_ch.sample_im <= 16'(im);
    in_ch.last      <= last;
    do @(posedge clk); while (!in_ch.ready);
    items++;
    if (cmd == 1'b0) begin
      shadow_re[idx] = longint'($signed(16'(re)));
      shadow_im[idx] = longint'($signed(16'(im)));
      stored[idx]    = 1'b1;
      settle_cycles  = 4;
      if (last) begin
        transform_shadow();
        settle_cycles = fft_cycles(size_code);
      end
    end else begin
      b.idx = 10'(idx);
      b.re  = has_exp ? 26'(exp_re) : 26'(shadow_re[idx]);
      b.im  = has_exp ? 26'(exp_im) : 26'(shadow_im[idx]);
      pending_bins.push_back(b);
      settle_cycles = 4;
    end
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // Any index that already holds a sample, preferring the transform span.
  function automatic int rand_stored(int span);
    int k;
    k = $urandom_range(0, span - 1);
    if ($urandom_range(0, 5) == 0) k = $urandom_range(0, DEPTH - 1);
    while (!stored[k]) k = (k + 1) % DEPTH;
    return k;
  endfunction

  // Directed part, size two. A read right after a write returns the sample
  // unchanged, so those rows carry their bin typed in.
  row_t directed[] = '{
    '{0, 0,    32767, -32768, 0, 0, 0, 0},
    '{1, 0,    0, 0, 0, 1, 32767, -32768},
    '{0, 1023, -32768, 32767, 0, 0, 0, 0},
    '{1, 1023, 0, 0, 0, 1, -32768, 32767},
    '{0, 1,    0, 0, 0, 0, 0, 0},
    '{1, 1,    0, 0, 0, 1, 0, 0},
    '{0, 1,    -1, 1, 1, 0, 0, 0},
    '{1, 0,    0, 0, 0, 0, 0, 0},
    '{1, 1,    0, 0, 0, 0, 0, 0},
    '{0, 0,    -32768, -32768, 0, 0, 0, 0},
    '{0, 1,    -32768, -32768, 1, 0, 0, 0},
    '{1, 0,    0, 0, 0, 0, 0, 0},
    '{1, 1,    0, 0, 0, 0, 0, 0},
    '{0, 512,  1, -1, 0, 0, 0, 0},
    '{1, 512,  0, 0, 0, 1, 1, -1},
    '{0, 0,    32767, 32767, 1, 0, 0, 0},
    '{1, 0,    0, 0, 0, 0, 0, 0},
    '{1, 1,    0, 0, 0, 0, 0, 0},
    '{1, 1023, 0, 0, 0, 0, 0, 0}
  };

  // Stimulus: directed rows, one full-size transform, a clamped oversize
  // transform over the same data, then random phases.
  initial begin
    int code;
    int span;
    int n_reads;
    int rand_start;
    for (int k = 0; k <= DEPTH; k++) cos_rom[k] = quarter_cos(k);
    errors          = 0;
    items           = 0;
    settle_cycles   = 0;
    calm            = 1'b0;
    stim_done       = 1'b0;
    size_code       = 10;
    inv_mode        = 1'b0;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= r2fft_pkg::CFG_POINTS_LOG2;
    cfg_data        <= 4'd0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= 1'b0;
    in_ch.index     <= 10'd0;
    in_ch.sample_re <= 16'sd0;
    in_ch.sample_im <= 16'sd0;
    in_ch.last      <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A size code of zero behaves as size two.
    set_mode(0, 1'b0);
    foreach (directed[r])
      send(directed[r].cmd, directed[r].idx, directed[r].re, directed[r].im,
           directed[r].last, directed[r].has_exp, directed[r].exp_re, directed[r].exp_im);

    // Full size: fill every entry, transform, sample the bins.
    set_mode(10, 1'b0);
    calm = 1'b1;
    for (int i = 0; i < DEPTH; i++) send(0, i, rand_sample(), rand_sample(), i == DEPTH - 1);
    calm = 1'b0;
    for (int i = 0; i < 20; i++) send(1, rand_stored(DEPTH), 0, 0, 0);

    // Oversize code clamps to full size; transforming grown data saturates.
    set_mode(15, 1'b1);
    send(0, 5, 32767, -32768, 0);
    send(0, 700, -32768, 32767, 1);
    for (int i = 0; i < 12; i++) send(1, rand_stored(DEPTH), 0, 0, 0);

    rand_start = items;
    while (items - rand_start < RAND_ITEMS) begin
      code = $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) code = $urandom_range(10, 15);
      else if ($urandom_range(0, 9) == 0) code = $urandom_range(6, 7);
      set_mode(code, $urandom_range(0, 1));
      calm = ($urandom_range(0, 3) == 0);
      span = 1 << eff_log2(code);
      if ($urandom_range(0, 5) != 0) begin
        // Well-formed block: load the span, stray writes and reads mixed in.
        for (int i = 0; i < span; i++) begin
          if ($urandom_range(0, 7) == 0) send(0, $urandom_range(0, DEPTH - 1),
                                              rand_sample(), rand_sample(), 0);
          if ($urandom_range(0, 7) == 0) send(1, rand_stored(span), 0, 0, 0);
          send(0, i, rand_sample(), rand_sample(), i == span - 1);
        end
        n_reads = $urandom_range(2, span + 2);
        for (int i = 0; i < n_reads; i++) send(1, rand_stored(span), 0, 0, 0);
      end else begin
        // Loose traffic; a start is issued only over a fully loaded span.
        for (int i = 0; i < $urandom_range(3, 12); i++) begin
          if ($urandom_range(0, 1) == 0) send(1, rand_stored(span), 0, 0, 0);
          else send(0, $urandom_range(0, DEPTH - 1), rand_sample(), rand_sample(),
                    ($urandom_range(0, 3) == 0) && span_stored(code) && span < 64);
        end
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: stall at random, then check each transfer against the
  // oldest expected bin.
  initial begin
    int   stall;
    bin_t want;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_bins.size() == 0) begin
        report("unexpected bin at index", out_ch.out_index, -1);
      end else begin
        want = pending_bins.pop_front();
        if (out_ch.out_index !== want.idx) report("out_index", out_ch.out_index, want.idx);
        if (out_ch.out_re !== want.re) report("out_re", out_ch.out_re, want.re);
        if (out_ch.out_im !== want.im) report("out_im", out_ch.out_im, want.im);
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("radix2_dit_fft_inplace_unit: mismatch");
      $finish;
    end
  end

  // End of run: drain the expected bins, allow the block to settle, report.
  initial begin
    wait (stim_done);
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (settle_cycles + 20) @(posedge clk);
    if (errors == 0) begin
      $display("radix2_dit_fft_inplace_unit: match");
    end else begin
      $display("radix2_dit_fft_inplace_unit: mismatch");
    end
    $finish;
  end

endmodule
